/* rtl/core/etd_pkg.sv */
`timescale 1ns / 1ps

package etd_pkg;

    localparam int CMD_W   = 2;
    localparam int TC_W    = 16;
    localparam int REQ_W   = 7;
    localparam int ST_W    = 2;
    localparam int EVI_W   = 8;
    localparam int TRI_W   = 16;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 9;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;
    localparam int RIDX_W  = PADDR_W - 2;

    localparam logic [CFG_W-1:0] EVENT_TOTAL_RST = 9'd256;
    localparam logic [CFG_W-1:0] MAX_ACTIVE_RST  = 9'd1;

    localparam logic [RIDX_W-1:0] REG_EVENT_TOTAL = 1'b0;
    localparam logic [RIDX_W-1:0] REG_MAX_ACTIVE  = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FETCH = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_ACT   = 2'd3
    } cmd_e;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NONE  = 2'd3
    } status_e;

    typedef struct packed {
        logic [CFG_W-1:0] event_total;
        logic [CFG_W-1:0] max_active;
    } cfg_t;

    typedef struct packed {
        status_e          status;
        logic [EVI_W-1:0] event_index;
        logic [TRI_W-1:0] track_index;
        logic [VAL_W-1:0] value;
        logic             has_tracks;
        logic             done_res;
        logic             last;
    } res_t;

endpackage

/* rtl/core/etd_if.sv */
`timescale 1ns / 1ps

interface etd_in_if import etd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [TC_W-1:0]  track_count;
    logic [REQ_W-1:0] request_count;

    modport source (output valid, output cmd, output track_count, output request_count,
                    input ready);
    modport sink (input valid, input cmd, input track_count, input request_count,
                  output ready);
endinterface

interface etd_out_if import etd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [EVI_W-1:0] event_index;
    logic [TRI_W-1:0] track_index;
    logic [VAL_W-1:0] value;
    logic             has_tracks;
    logic             done_res;
    logic             last;

    modport source (output valid, output status, output event_index, output track_index,
                    output value, output has_tracks, output done_res, output last,
                    input ready);
    modport sink (input valid, input status, input event_index, input track_index,
                  input value, input has_tracks, input done_res, input last,
                  output ready);
endinterface

/* rtl/core/etd_cfg.sv */
`timescale 1ns / 1ps

module etd_cfg import etd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [CFG_W-1:0]  event_total_reg;
    logic [CFG_W-1:0]  max_active_reg;
    logic [RIDX_W-1:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_total_reg <= EVENT_TOTAL_RST;
            max_active_reg  <= MAX_ACTIVE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_EVENT_TOTAL: event_total_reg <= pwdata[CFG_W-1:0];
                REG_MAX_ACTIVE:  max_active_reg  <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_EVENT_TOTAL: prdata = DATA_W'(event_total_reg);
            REG_MAX_ACTIVE:  prdata = DATA_W'(max_active_reg);
        endcase
    end

    assign cfg.event_total = event_total_reg;
    assign cfg.max_active  = max_active_reg;

endmodule

/* rtl/core/etd_ctrl.sv */
`timescale 1ns / 1ps

module etd_ctrl import etd_pkg::*;
#(
    parameter int MAX_EVENTS = 256,
    parameter int TRACK_BITS = 16,
    parameter int BASKET_MAX = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    etd_in_if.sink    req,
    etd_out_if.source rsp
);

    localparam int EV_CAP = (MAX_EVENTS < 511) ? MAX_EVENTS : 511;
    localparam int CNT_W  = $clog2(EV_CAP + 1);
    localparam int IDX_W  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW     = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
    localparam int DISP_W = TRACK_BITS + 1;

    localparam logic [CFG_W-1:0] EV_CAP_C   = CFG_W'(EV_CAP);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(MAX_EVENTS - 1);
    localparam logic [REQ_W-1:0] BASKET_LIM = REQ_W'(BASKET_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ACT,
        S_EVAL,
        S_RD,
        S_NONE
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      loaded_reg;
    logic [CNT_W-1:0]      la1_reg;
    logic [CNT_W-1:0]      active_reg;
    logic [IDX_W-1:0]      ce_reg;
    logic [DISP_W-1:0]     disp_reg;
    logic                  tracks_reg;
    logic                  served_reg;
    logic                  done_reg;
    logic [REQ_W-1:0]      reqn_reg;
    logic [REQ_W-1:0]      k_reg;
    logic [TRACK_BITS-1:0] tc_reg;
    logic                  res_valid_reg;
    res_t                  res_reg;

    logic [TRACK_BITS-1:0] primary_mem [MAX_EVENTS];
    logic [TRACK_BITS-1:0] rdata_reg;

    cmd_e                  cmd_in;
    logic [REQ_W-1:0]      req_sat;
    logic [CFG_W-1:0]      eff;
    logic [CFG_W-1:0]      act_x;
    logic [CFG_W-1:0]      la_x;
    logic [CFG_W-1:0]      steps;
    logic [CFG_W-1:0]      room;
    logic [CFG_W-1:0]      n_act;
    logic                  can_act;
    logic [TRACK_BITS-1:0] prim;
    logic                  hit;
    logic                  at_end;
    logic                  is_final;
    logic [DISP_W-1:0]     disp_inc;
    logic [REQ_W-1:0]      k_inc;
    logic                  out_free;
    logic                  full;
    logic                  mem_we;
    logic                  emit;
    res_t                  emit_res;

    assign cmd_in   = cmd_e'(req.cmd);
    assign req_sat  = (req.request_count > BASKET_LIM) ? BASKET_LIM : req.request_count;
    assign out_free = !res_valid_reg || rsp.ready;

    // A zero event total counts as one slot, and a value above the pool as the whole pool.
    always_comb
    begin
        if (cfg.event_total == '0)
        begin
            eff = CFG_W'(1);
        end
        else if (cfg.event_total > EV_CAP_C)
        begin
            eff = EV_CAP_C;
        end
        else
        begin
            eff = cfg.event_total;
        end
    end

    // The admission loop in closed form: stop at the window limit or once the
    // final slot is admitted, whichever comes first. la1_reg holds last active + 1.
    always_comb
    begin
        act_x   = CFG_W'(active_reg);
        la_x    = CFG_W'(la1_reg);
        steps   = (eff > la_x) ? (eff - la_x) : CFG_W'(1);
        room    = cfg.max_active - act_x;
        can_act = !served_reg && (act_x < cfg.max_active);
        n_act   = can_act ? ((room < steps) ? room : steps) : '0;
    end

    // Slots at or above the fill count were never loaded and read as zero.
    assign prim     = (CW'(ce_reg) < CW'(loaded_reg)) ? rdata_reg : '0;
    assign hit      = disp_reg < {1'b0, prim};
    assign at_end   = ((CW'(ce_reg) + CW'(1)) >= CW'(la1_reg)) || (ce_reg == LAST_SLOT);
    assign is_final = (CW'(ce_reg) + CW'(1)) == CW'(eff);
    assign disp_inc = (&disp_reg) ? disp_reg : (disp_reg + DISP_W'(1));
    assign k_inc    = k_reg + REQ_W'(1);
    assign full     = CFG_W'(loaded_reg) >= eff;
    assign mem_we   = (state_reg == S_LOAD) && out_free && !full;

    always_comb
    begin
        emit                = 1'b0;
        emit_res            = '0;
        emit_res.has_tracks = tracks_reg;
        emit_res.done_res   = done_reg;
        emit_res.last       = 1'b1;
        unique case (state_reg)
            S_LOAD:
            begin
                emit = out_free;
                if (full)
                begin
                    emit_res.status = ST_FULL;
                end
                else if (tc_reg == '0)
                begin
                    emit_res.status      = ST_EMPTY;
                    emit_res.event_index = EVI_W'(loaded_reg);
                end
                else
                begin
                    emit_res.status      = ST_OK;
                    emit_res.event_index = EVI_W'(loaded_reg);
                    emit_res.value       = VAL_W'(tc_reg);
                end
            end
            S_ACT:
            begin
                emit                = out_free;
                emit_res.status     = ST_OK;
                emit_res.value      = VAL_W'(n_act);
                emit_res.has_tracks = tracks_reg || can_act;
            end
            S_EVAL:
            begin
                emit                 = out_free && hit;
                emit_res.status      = ST_OK;
                emit_res.event_index = EVI_W'(ce_reg);
                emit_res.track_index = TRI_W'(disp_reg);
                emit_res.last        = (k_inc == reqn_reg);
            end
            S_NONE:
            begin
                emit            = out_free;
                emit_res.status = ST_NONE;
            end
            S_IDLE, S_RD:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            primary_mem[IDX_W'(loaded_reg)] <= tc_reg;
        end
        rdata_reg <= primary_mem[ce_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            la1_reg       <= '0;
            active_reg    <= '0;
            ce_reg        <= '0;
            disp_reg      <= '0;
            tracks_reg    <= 1'b0;
            served_reg    <= 1'b0;
            done_reg      <= 1'b0;
            reqn_reg      <= '0;
            k_reg         <= '0;
            tc_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (emit)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= emit_res;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        unique case (cmd_in)
                            CMD_LOAD:
                            begin
                                tc_reg    <= TRACK_BITS'(req.track_count);
                                state_reg <= S_LOAD;
                            end
                            CMD_FETCH:
                            begin
                                reqn_reg  <= req_sat;
                                k_reg     <= '0;
                                state_reg <= (tracks_reg && (req_sat != '0)) ? S_EVAL : S_NONE;
                            end
                            CMD_DONE:
                            begin
                                if (active_reg != '0)
                                begin
                                    active_reg <= active_reg - CNT_W'(1);
                                end
                                state_reg <= S_ACT;
                            end
                            CMD_ACT:
                            begin
                                state_reg <= S_ACT;
                            end
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (out_free)
                    begin
                        if (!full)
                        begin
                            loaded_reg <= loaded_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_ACT:
                begin
                    if (out_free)
                    begin
                        active_reg <= CNT_W'(act_x + n_act);
                        la1_reg    <= CNT_W'(la_x + n_act);
                        served_reg <= served_reg || (can_act && (n_act == steps));
                        tracks_reg <= tracks_reg || can_act;
                        state_reg  <= S_IDLE;
                    end
                end
                S_EVAL:
                begin
                    // Only the current event's dispatched count is ever touched, so it
                    // lives here and starts from zero whenever the walk moves on.
                    if (hit)
                    begin
                        if (out_free)
                        begin
                            disp_reg <= disp_inc;
                            k_reg    <= k_inc;
                            if (k_inc == reqn_reg)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else if (at_end)
                    begin
                        disp_reg   <= disp_inc;
                        tracks_reg <= 1'b0;
                        if (is_final)
                        begin
                            done_reg <= 1'b1;
                        end
                        state_reg <= S_NONE;
                    end
                    else
                    begin
                        ce_reg    <= ce_reg + IDX_W'(1);
                        disp_reg  <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EVAL;
                end
                S_NONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = res_valid_reg;
    assign rsp.status      = res_reg.status;
    assign rsp.event_index = res_reg.event_index;
    assign rsp.track_index = res_reg.track_index;
    assign rsp.value       = res_reg.value;
    assign rsp.has_tracks  = res_reg.has_tracks;
    assign rsp.done_res    = res_reg.done_res;
    assign rsp.last        = res_reg.last;

    a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (la1_reg != '0) |-> (CW'(ce_reg) < CW'(la1_reg)))
        else $error("current event passed the last active event");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(active_reg) <= CW'(la1_reg))
        else $error("active count exceeds activated events");

    a_served_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        served_reg |=> served_reg)
        else $error("served flag dropped");

    a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EVAL) || (state_reg == S_RD)) |-> (tracks_reg && (k_reg < reqn_reg)))
        else $error("fetch walk running without tracks or past its request");

endmodule

/* rtl/core/event_track_dispatcher.sv */
`timescale 1ns / 1ps

// Event track dispatcher: a pool of event slots whose primary-track counts sit in a
// synchronous memory with a registered read, loaded in slot order and walked
// by fetch commands. Each input transaction is handled to completion before the next
// is accepted; results leave through an output register, so the next transaction is
// taken while the final result still waits. Load, activate and complete are accepted,
// then give a result. A fetch is accepted, then hands out one track per cycle while
// the output register is free, spends an evaluation plus the memory read of the next
// slot's count on each drained event passed over, and gives a closing no-track result
// when there is one; a walk that stops on the last active event drained spends one
// more evaluation on that event before the closing result. Slots not yet loaded read
// as zero through a fill count, so there is no clearing pass after reset.
module event_track_dispatcher import etd_pkg::*;
#(
    parameter int MAX_EVENTS = 256,
    parameter int TRACK_BITS = 16,
    parameter int BASKET_MAX = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    etd_in_if.sink             req,
    etd_out_if.source          rsp
);

    cfg_t cfg;

    etd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    etd_ctrl #(
        .MAX_EVENTS (MAX_EVENTS),
        .TRACK_BITS (TRACK_BITS),
        .BASKET_MAX (BASKET_MAX)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

/* tb/tb_event_track_dispatcher.sv */
`timescale 1ns / 1ps

module tb_event_track_dispatcher;
    import etd_pkg::*;

    localparam int POOL_SLOTS   = 256;
    localparam int BASKET_LIMIT = 64;
    localparam int COUNT_CEIL   = 17'h1FFFF;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 6000;
    localparam int DRAIN_CYCLES = 20;

    // Mirror of the event pool: it advances on every accepted command and keeps
    // the results that the block owes, oldest first.
    class event_pool_mirror;
        logic [TC_W-1:0] primary[POOL_SLOTS];
        logic [16:0]     dispatched[POOL_SLOTS];
        int unsigned     loaded, stored, current, active, completed;
        int              last_active;
        bit              tracks_flag, served, done_flag;
        int unsigned     event_total, max_active;
        res_t            owed[$];
        int unsigned     mismatches, checked, tracks_out;

        function new();
            foreach (primary[i]) begin
                primary[i] = '0;
                dispatched[i] = '0;
            end
            loaded = 0;
            stored = 0;
            current = 0;
            active = 0;
            completed = 0;
            last_active = -1;
            tracks_flag = 0;
            served = 0;
            done_flag = 0;
            event_total = EVENT_TOTAL_RST;
            max_active = MAX_ACTIVE_RST;
            mismatches = 0;
            checked = 0;
            tracks_out = 0;
        endfunction

        function void set_register(logic [RIDX_W-1:0] idx, int unsigned val);
            if (idx == REG_EVENT_TOTAL)
                event_total = val & 32'h1FF;
            else if (idx == REG_MAX_ACTIVE)
                max_active = val & 32'h1FF;
        endfunction

        // Out-of-range totals are clamped into 1..POOL_SLOTS.
        function int unsigned pool_size();
            if (event_total == 0)
                return 1;
            if (event_total > POOL_SLOTS)
                return POOL_SLOTS;
            return event_total;
        endfunction

        function void owe(status_e st, int unsigned ev, int unsigned tr, int unsigned val,
                          bit fin);
            res_t r;
            r.status = st;
            r.event_index = ev[EVI_W-1:0];
            r.track_index = tr[TRI_W-1:0];
            r.value = val[VAL_W-1:0];
            r.has_tracks = tracks_flag;
            r.done_res = done_flag;
            r.last = fin;
            owed.push_back(r);
        endfunction

        function int unsigned admit_events();
            int unsigned n;
            int          fin;
            n = 0;
            fin = int'(pool_size()) - 1;
            if (served)
                return 0;
            while (active < max_active && !served)
            begin
                active++;
                last_active++;
                n++;
                if (last_active >= fin)
                    served = 1;
                tracks_flag = 1;
            end
            return n;
        endfunction

        // Walks forward from the current event until a track is found or the last
        // active event turns out drained.
        function bit next_track(output int unsigned ev, output int unsigned tr);
            int unsigned e, itr;
            bit          at_end, searching, found;
            searching = 1;
            found = 0;
            ev = 0;
            tr = 0;
            while (searching)
            begin
                e = current;
                at_end = (int'(e) >= last_active) || (e >= POOL_SLOTS - 1);
                if (e >= POOL_SLOTS)
                begin
                    tracks_flag = 0;
                    searching = 0;
                end
                else
                begin
                    itr = dispatched[e];
                    if (dispatched[e] < COUNT_CEIL)
                        dispatched[e] = dispatched[e] + 1'b1;
                    if (itr < primary[e])
                    begin
                        ev = e;
                        tr = itr;
                        found = 1;
                        searching = 0;
                    end
                    else if (at_end)
                    begin
                        tracks_flag = 0;
                        if (e == pool_size() - 1)
                            done_flag = 1;
                        searching = 0;
                    end
                    else
                        current = e + 1;
                end
            end
            return found;
        endfunction

        function void take_command(cmd_e cmd, logic [TC_W-1:0] tc, logic [REQ_W-1:0] rq);
            int unsigned e, want, k, ev, tr;
            bit          stopped;
            case (cmd)
                CMD_LOAD:
                begin
                    if (loaded >= pool_size())
                        owe(ST_FULL, 0, 0, 0, 1);
                    else
                    begin
                        e = loaded;
                        loaded++;
                        primary[e] = tc;
                        if (tc == 0)
                            owe(ST_EMPTY, e, 0, 0, 1);
                        else
                        begin
                            stored++;
                            owe(ST_OK, e, 0, tc, 1);
                        end
                    end
                end
                CMD_FETCH:
                begin
                    want = (rq > BASKET_LIMIT) ? BASKET_LIMIT : rq;
                    k = 0;
                    stopped = !tracks_flag;
                    while (!stopped && k < want)
                    begin
                        if (next_track(ev, tr))
                        begin
                            owe(ST_OK, ev, tr, 0, 0);
                            tracks_out++;
                            k++;
                        end
                        else
                            stopped = 1;
                    end
                    if (k < want || k == 0)
                        owe(ST_NONE, 0, 0, 0, 1);
                    else
                    begin
                        // A fully met request closes on its final track, which carries
                        // the flags as they stand after the whole walk.
                        owed[owed.size()-1].has_tracks = tracks_flag;
                        owed[owed.size()-1].done_res = done_flag;
                        owed[owed.size()-1].last = 1'b1;
                    end
                end
                CMD_DONE:
                begin
                    if (active > 0)
                        active--;
                    if (completed < 32'h1FF)
                        completed++;
                    owe(ST_OK, 0, 0, admit_events(), 1);
                end
                default:
                    owe(ST_OK, 0, 0, admit_events(), 1);
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void match_result(res_t got);
            res_t exp;
            checked++;
            if (owed.size() == 0)
            begin
                $error("result with nothing owed: status %0d event %0d track %0d",
                       got.status, got.event_index, got.track_index);
                mismatches++;
                return;
            end
            exp = owed.pop_front();
            check_field("status", 32'(exp.status), 32'(got.status));
            check_field("event_index", 32'(exp.event_index), 32'(got.event_index));
            check_field("track_index", 32'(exp.track_index), 32'(got.track_index));
            check_field("value", 32'(exp.value), 32'(got.value));
            check_field("has_tracks", 32'(exp.has_tracks), 32'(got.has_tracks));
            check_field("done_res", 32'(exp.done_res), 32'(got.done_res));
            check_field("last", 32'(exp.last), 32'(got.last));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    etd_in_if  cmd_ch ();
    etd_out_if res_ch ();

    event_track_dispatcher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (cmd_ch),
        .rsp     (res_ch)
    );

    event_pool_mirror mirror;
    bit               quiet;
    int unsigned      commands_sent;
    int unsigned      settings_used;
    int unsigned      idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_cmd(cmd_e c, int unsigned tc, int unsigned rq);
        int               gap;
        logic [TC_W-1:0]  tc_w;
        logic [REQ_W-1:0] rq_w;
        tc_w = TC_W'(tc);
        rq_w = REQ_W'(rq);
        gap = pick_gap();
        if ($urandom_range(0, 24) == 0)
            quiet = !quiet;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.cmd = c;
        cmd_ch.track_count = tc_w;
        cmd_ch.request_count = rq_w;
        cmd_ch.valid = 1'b1;
        do @(posedge clk); while (!cmd_ch.ready);
        mirror.take_command(c, tc_w, rq_w);
        commands_sent++;
    endtask

    // Drops the request line and waits until every owed result has come back.
    task automatic settle();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (mirror.owed.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [RIDX_W-1:0] idx, int unsigned val);
        logic [DATA_W-1:0] want;
        want = DATA_W'(val & 32'h1FF);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = DATA_W'(val);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        mirror.set_register(idx, val);
        @(negedge clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("register %0d read-back: expected %0d, got %0d", idx, want, prdata);
            mirror.mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_window(int unsigned total, int unsigned width);
        settle();
        write_reg(REG_EVENT_TOTAL, total);
        write_reg(REG_MAX_ACTIVE, width);
        settings_used++;
    endtask

    // Mostly small events that drain in a few fetches, so the walk keeps moving
    // through the pool; a slice of the traffic is noise with random fields.
    task automatic random_run(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(CMD_LOAD, 0, $urandom_range(0, 127));
                else if ($urandom_range(0, 9) == 0)
                    push_cmd(CMD_LOAD, $urandom_range(7, 40), $urandom_range(0, 127));
                else
                    push_cmd(CMD_LOAD, $urandom_range(1, 6), $urandom_range(0, 127));
            end
            else if (r < 62)
            begin
                if ($urandom_range(0, 9) == 0)
                    push_cmd(CMD_FETCH, $urandom, $urandom_range(0, 127));
                else
                    push_cmd(CMD_FETCH, $urandom, $urandom_range(1, 8));
            end
            else if (r < 80)
                push_cmd(CMD_DONE, $urandom, $urandom);
            else if (r < 92)
                push_cmd(CMD_ACT, $urandom, $urandom);
            else
                push_cmd(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 3), $urandom);
        end
    endtask

    // Result sink with random back-pressure.
    initial
    begin
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                res_ch.ready = 1'b0;
                hold--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.status = status_e'(res_ch.status);
                got.event_index = res_ch.event_index;
                got.track_index = res_ch.track_index;
                got.value = res_ch.value;
                got.has_tracks = res_ch.has_tracks;
                got.done_res = res_ch.done_res;
                got.last = res_ch.last;
                mirror.match_result(got);
            end
            if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        mirror = new();
        quiet = 0;
        commands_sent = 0;
        settings_used = 1;
        idle_cycles = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd = CMD_LOAD;
        cmd_ch.track_count = '0;
        cmd_ch.request_count = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Opening walk at the reset window: nothing flagged, a completion with no
        // active event, zero and oversized requests, an empty slot, drained events.
        push_cmd(CMD_FETCH, 0, 5);
        push_cmd(CMD_DONE, 0, 0);
        push_cmd(CMD_ACT, 0, 0);
        push_cmd(CMD_FETCH, 0, 0);
        push_cmd(CMD_LOAD, 0, 0);
        push_cmd(CMD_LOAD, 3, 0);
        push_cmd(CMD_LOAD, 1, 0);
        push_cmd(CMD_FETCH, 0, 127);
        push_cmd(CMD_DONE, 0, 0);
        push_cmd(CMD_FETCH, 0, 2);
        push_cmd(CMD_FETCH, 0, 1);
        push_cmd(CMD_FETCH, 0, 64);
        push_cmd(CMD_ACT, 0, 0);

        set_window(256, 3);
        random_run(90);
        set_window(256, 1);
        random_run(40);

        // A lowered total stops activation for good once it is reached.
        set_window(200, 256);
        random_run(60);

        set_window(1, 511);
        push_cmd(CMD_ACT, 0, 0);
        push_cmd(CMD_DONE, 0, 0);
        push_cmd(CMD_LOAD, 2, 0);
        push_cmd(CMD_FETCH, 0, 64);

        // A total of zero counts as one slot, so every load reports the pool full.
        set_window(0, 0);
        push_cmd(CMD_LOAD, 5, 0);
        push_cmd(CMD_ACT, 0, 0);
        push_cmd(CMD_DONE, 0, 0);
        push_cmd(CMD_FETCH, 0, 3);

        set_window(511, 1);
        push_cmd(CMD_LOAD, 16'hFFFF, 0);
        push_cmd(CMD_LOAD, 16'h8000, 0);
        push_cmd(CMD_LOAD, 16'h5555, 0);
        push_cmd(CMD_LOAD, 16'hAAAA, 0);
        repeat (4) push_cmd(CMD_LOAD, $urandom, $urandom);
        push_cmd(CMD_FETCH, 0, 64);
        push_cmd(CMD_ACT, 0, 0);
        push_cmd(CMD_FETCH, 0, 127);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.owed.size() != 0)
        begin
            $error("%0d results never arrived", mirror.owed.size());
            mirror.mismatches++;
        end
        $display("Ran %0d commands over %0d window settings; %0d results compared.",
                 commands_sent, settings_used, mirror.checked);
        $display("Tracks handed out: %0d; events loaded: %0d, non-empty: %0d.",
                 mirror.tracks_out, mirror.loaded, mirror.stored);
        if (mirror.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
